// File: rtl/pngu_pkg.sv
// Shared types and constants of the PNG scanline unfilter.
package pngu_pkg;

  localparam int unsigned MaxLineBytesDef  = 8192;
  localparam int unsigned MaxPixelBytesDef = 8;

  localparam int unsigned PixelBytesW = 4;
  localparam int unsigned LineBytesW  = 14;
  localparam int unsigned CfgDataW    = 14;
  localparam int unsigned CfgIdxW     = 1;

  localparam logic [PixelBytesW-1:0] PixelBytesRst = PixelBytesW'(4);
  localparam logic [LineBytesW-1:0]  LineBytesRst  = LineBytesW'(4096);

  typedef enum logic [CfgIdxW-1:0] {
    RegPixelBytes = 1'b0,
    RegLineBytes  = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FiltNone  = 3'd0,
    FiltSub   = 3'd1,
    FiltUp    = 3'd2,
    FiltPaeth = 3'd4,
    FiltBad   = 3'd5
  } filt_e;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0] recon_byte;
    logic       line_end;
    logic       bad_filter;
  } out_item_t;

endpackage

// File: rtl/pngu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module pngu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/png_scanline_unfilter.sv
// PNG scanline unfilter: filter type decode, prior-row store and byte reconstruction.
//
// The input channel takes the inflated stream one byte per transfer. The
// first byte of a scanline is its filter type and gives no result; each of
// the following line_bytes data bytes gives one result transfer with the
// rebuilt byte, a flag on the last byte of the line and a flag for an unsupported
// filter (Average or an unknown code), whose bytes pass raw. start_image on a byte
// aborts any open line and takes that byte as the filter type of the first row of a
// new image, whose upper row reads zero. The user writes pixel_bytes and line_bytes
// on the configuration port only while idle; the block itself does not enforce it.
//
// A data byte is registered in the middle stage at its transfer, and the prior-row
// RAM is read at that same edge; when the middle stage advances, the filtered byte
// loads into the output register. One byte is taken every cycle unless the output
// stalls; the RAM is read and written once per data byte on separate ports.
// A stall at the output holds the output register and the middle stage, and
// input ready is low while both are occupied and the receiver stalls. Reset
// empties the pipeline, restores the register defaults and expects a filter
// byte; the RAM needs no clearing because the first row ignores its read data.
module png_scanline_unfilter #(
  parameter int unsigned MaxLineBytes  = pngu_pkg::MaxLineBytesDef,
  parameter int unsigned MaxPixelBytes = pngu_pkg::MaxPixelBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pngu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pngu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pngu_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pngu_pkg::out_item_t        out_data_o
);

  import pngu_pkg::*;

  localparam int unsigned AddrW    = $clog2(MaxLineBytes);
  localparam int unsigned PosW     = $clog2(MaxLineBytes + 1);
  localparam int unsigned CmpW     = (PosW > LineBytesW) ? PosW : LineBytesW;
  localparam int unsigned HistIdxW = (MaxPixelBytes > 1) ? $clog2(MaxPixelBytes) : 1;

  logic [PixelBytesW-1:0] pixel_bytes_q;
  logic [LineBytesW-1:0]  line_bytes_q;

  logic [PosW-1:0] pos_q, pos_d;
  filt_e           filt_q, filt_d;
  logic            first_row_q, first_row_d;

  logic            s1_valid_q;
  filt_e           s1_filt_q;
  logic            s1_edge_q;
  logic            s1_first_q;
  logic            s1_last_q;
  logic [7:0]      s1_raw_q;
  logic [AddrW-1:0] s1_addr_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [7:0] left_q   [MaxPixelBytes];
  logic [7:0] upleft_q [MaxPixelBytes];

  logic                   in_xfer, s1_go, is_filt_byte, data_xfer;
  logic [PixelBytesW-1:0] bpp_eff, bpp_m1;
  logic [HistIdxW-1:0]    hist_idx;
  logic [CmpW-1:0]        len_eff, lb_ext;
  logic [PosW-1:0]        idx;
  logic                   last, edge_px;
  logic [AddrW-1:0]       rd_addr;
  logic [7:0]             ram_rdata;
  logic [7:0]             a_px, b_px, c_px, pred, rec;
  logic signed [9:0]      pa, pb, pc;
  logic                   bad;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_bytes_q <= PixelBytesRst;
      line_bytes_q  <= LineBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegPixelBytes: pixel_bytes_q <= cfg_data_i[PixelBytesW-1:0];
        RegLineBytes:  line_bytes_q  <= cfg_data_i[LineBytesW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pixel_bytes_q == '0) begin
      bpp_eff = PixelBytesW'(1);
    end else if (pixel_bytes_q > PixelBytesW'(MaxPixelBytes)) begin
      bpp_eff = PixelBytesW'(MaxPixelBytes);
    end else begin
      bpp_eff = pixel_bytes_q;
    end
    bpp_m1   = bpp_eff - PixelBytesW'(1);
    hist_idx = bpp_m1[HistIdxW-1:0];

    lb_ext = CmpW'(line_bytes_q);
    if (lb_ext == '0) begin
      len_eff = CmpW'(1);
    end else if (lb_ext > CmpW'(MaxLineBytes)) begin
      len_eff = CmpW'(MaxLineBytes);
    end else begin
      len_eff = lb_ext;
    end
  end

  // Sequencing of filter and data bytes at the input transfer.
  assign s1_go        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o   = !s1_valid_q || s1_go;
  assign in_xfer      = in_valid_i && in_ready_o;
  assign is_filt_byte = in_data_i.start_image || (pos_q == '0);
  assign data_xfer    = in_xfer && !is_filt_byte;

  assign idx     = pos_q - PosW'(1);
  assign rd_addr = idx[AddrW-1:0];
  assign last    = CmpW'(pos_q) >= len_eff;
  assign edge_px = CmpW'(idx) >= CmpW'(bpp_eff);

  always_comb begin
    pos_d       = pos_q;
    filt_d      = filt_q;
    first_row_d = first_row_q;
    if (in_xfer) begin
      if (is_filt_byte) begin
        pos_d = PosW'(1);
        if (in_data_i.start_image) begin
          first_row_d = 1'b1;
        end
        unique case (in_data_i.raw_byte)
          8'd0, 8'd1, 8'd2, 8'd4: filt_d = filt_e'(in_data_i.raw_byte[2:0]);
          default:                filt_d = FiltBad;
        endcase
      end else if (last) begin
        pos_d       = '0;
        first_row_d = 1'b0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      filt_q      <= FiltNone;
      first_row_q <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      filt_q      <= filt_d;
      first_row_q <= first_row_d;
      if (data_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_xfer) begin
      s1_filt_q  <= filt_q;
      s1_edge_q  <= edge_px;
      s1_first_q <= first_row_q;
      s1_last_q  <= last;
      s1_raw_q   <= in_data_i.raw_byte;
      s1_addr_q  <= rd_addr;
    end
    if (s1_go) begin
      out_q.recon_byte <= rec;
      out_q.line_end   <= s1_last_q;
      out_q.bad_filter <= bad;
    end
  end

  pngu_ram #(
    .Width(8),
    .Depth(MaxLineBytes)
  ) u_prior_row (
    .clk_i  (clk_i),
    .we_i   (s1_go),
    .waddr_i(s1_addr_q),
    .wdata_i(rec),
    .re_i   (data_xfer),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // Reconstruction of the byte in the middle stage.
  always_comb begin
    b_px = s1_first_q ? 8'd0 : ram_rdata;
    a_px = s1_edge_q ? left_q[hist_idx] : 8'd0;
    c_px = s1_edge_q ? upleft_q[hist_idx] : 8'd0;

    pa = $signed({2'b00, b_px}) - $signed({2'b00, c_px});
    pb = $signed({2'b00, a_px}) - $signed({2'b00, c_px});
    pc = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) begin
      pred = a_px;
    end else if (pb <= pc) begin
      pred = b_px;
    end else begin
      pred = c_px;
    end

    bad = 1'b0;
    unique case (s1_filt_q)
      FiltNone:  rec = s1_raw_q;
      FiltSub:   rec = s1_raw_q + a_px;
      FiltUp:    rec = s1_raw_q + b_px;
      FiltPaeth: rec = s1_raw_q + pred;
      default: begin
        rec = s1_raw_q;
        bad = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MaxPixelBytes; k++) begin
        left_q[k]   <= 8'd0;
        upleft_q[k] <= 8'd0;
      end
    end else if (s1_go) begin
      left_q[0]   <= rec;
      upleft_q[0] <= b_px;
      for (int k = 1; k < MaxPixelBytes; k++) begin
        left_q[k]   <= left_q[k-1];
        upleft_q[k] <= upleft_q[k-1];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_go |=> s1_valid_q && $stable(s1_addr_q))
    else $error("Middle stage lost or changed a stalled byte.");

  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && data_xfer |-> s1_addr_q != rd_addr)
    else $error("Prior-row read and write hit the same entry in one cycle.");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(in_xfer) |-> CmpW'(pos_q) <= len_eff)
    else $error("Byte position ran past the line length.");

  a_line_end_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    data_xfer && last |=> pos_q == '0 && !first_row_q)
    else $error("Line end did not return to the filter byte.");
`endif

endmodule

// File: tb/png_scanline_unfilter_tb.sv
// Self-checking testbench of the PNG scanline unfilter, driven through both handshakes.
module png_scanline_unfilter_tb;
  import pngu_pkg::*;

  localparam int unsigned MaxLine = MaxLineBytesDef;
  localparam int unsigned MaxPix = MaxPixelBytesDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomItems = 580;
  localparam logic [7:0] AvgCode = 8'd3;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we_q = 1'b0;
  cfg_reg_e cfg_idx_q = RegPixelBytes;
  logic [CfgDataW-1:0] cfg_data_q = '0;
  logic in_valid_q = 1'b0;
  logic in_ready_o;
  in_item_t in_data_q = '0;
  logic out_valid_o;
  logic out_ready_q = 1'b0;
  out_item_t out_data_o;

  logic [7:0] row_above [MaxLine];
  bit row_above_set [MaxLine];
  logic [7:0] left_hist [MaxPix];
  logic [7:0] upleft_hist [MaxPix];
  int unsigned col_pos = 0;
  filt_e cur_filter = FiltNone;
  bit first_row = 1'b1;
  int unsigned pix_cfg = 4;
  int unsigned len_cfg = 4096;

  out_item_t recon_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned burst_left = 0;
  filt_e usable_filt [4] = '{FiltNone, FiltSub, FiltUp, FiltPaeth};

  png_scanline_unfilter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we_q),
    .cfg_idx_i  (cfg_idx_q),
    .cfg_data_i (cfg_data_q),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : watchdog
    int unsigned cycle_cnt;
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : drive_out_ready
    logic [15:0] pat;
    int unsigned tick;
    pat = '1;
    tick = 0;
    forever begin
      @(posedge clk_i);
      if (tick % 64 == 0) begin
        pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      tick++;
      out_ready_q <= pat[0];
      pat = {pat[0], pat[15:1]};
    end
  end

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 100) $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  always @(negedge clk_i) begin : check_results
    out_item_t want;
    if (rst_n && out_valid_o && out_ready_q) begin
      if (recon_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_data_o));
      end else begin
        want = recon_q.pop_front();
        if (out_data_o.recon_byte !== want.recon_byte || out_data_o.line_end !== want.line_end
            || out_data_o.bad_filter !== want.bad_filter) begin
          flag_mismatch($sformatf("result %0d: got byte %h end %b bad %b, want %h %b %b",
                                  results_seen, out_data_o.recon_byte, out_data_o.line_end,
                                  out_data_o.bad_filter, want.recon_byte, want.line_end,
                                  want.bad_filter));
        end
      end
      results_seen++;
    end
  end

  function automatic int unsigned pixel_eff();
    if (pix_cfg == 0) return 1;
    return (pix_cfg > MaxPix) ? MaxPix : pix_cfg;
  endfunction

  function automatic int unsigned line_len_eff();
    if (len_cfg == 0) return 1;
    return (len_cfg > MaxLine) ? MaxLine : len_cfg;
  endfunction

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int p, pa, pb, pc;
    p = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // A data byte that would read a row entry never written starts a new image instead.
  function automatic bit reads_unwritten(input logic start);
    int unsigned idx;
    if (start || col_pos == 0 || first_row) return 1'b0;
    idx = (col_pos - 1 >= MaxLine) ? MaxLine - 1 : col_pos - 1;
    return !row_above_set[idx];
  endfunction

  task automatic unfilter_byte(input in_item_t item, output bit has_res, output out_item_t res);
    int unsigned bpp, len, idx, k;
    logic [7:0] a, b, c, rec;
    bit bad;
    bpp = pixel_eff();
    len = line_len_eff();
    has_res = 1'b0;
    res = '0;
    if (item.start_image) begin
      col_pos = 0;
      first_row = 1'b1;
    end
    if (col_pos == 0) begin
      case (item.raw_byte)
        8'(FiltNone), 8'(FiltSub), 8'(FiltUp), 8'(FiltPaeth): begin
          cur_filter = filt_e'(item.raw_byte[2:0]);
        end
        default: begin
          cur_filter = FiltBad;
        end
      endcase
      col_pos = 1;
      return;
    end
    idx = (col_pos - 1 >= MaxLine) ? MaxLine - 1 : col_pos - 1;
    b = first_row ? 8'h00 : row_above[idx];
    a = (idx >= bpp) ? left_hist[bpp-1] : 8'h00;
    c = (idx >= bpp) ? upleft_hist[bpp-1] : 8'h00;
    bad = 1'b0;
    case (cur_filter)
      FiltNone: rec = item.raw_byte;
      FiltSub: rec = item.raw_byte + a;
      FiltUp: rec = item.raw_byte + b;
      FiltPaeth: rec = item.raw_byte + paeth_pick(a, b, c);
      default: begin
        rec = item.raw_byte;
        bad = 1'b1;
      end
    endcase
    for (k = MaxPix - 1; k > 0; k--) begin
      left_hist[k] = left_hist[k-1];
      upleft_hist[k] = upleft_hist[k-1];
    end
    left_hist[0] = rec;
    upleft_hist[0] = b;
    row_above[idx] = rec;
    row_above_set[idx] = 1'b1;
    res.recon_byte = rec;
    res.line_end = (col_pos >= len);
    res.bad_filter = bad;
    has_res = 1'b1;
    if (col_pos >= len) begin
      col_pos = 0;
      first_row = 1'b0;
    end else begin
      col_pos++;
    end
  endtask

  task automatic send_byte(input logic [7:0] raw, input logic start);
    in_item_t item;
    out_item_t res;
    bit has_res;
    int unsigned gap;
    item.raw_byte = raw;
    item.start_image = start | reads_unwritten(start);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      in_valid_q <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_q <= 1'b1;
    in_data_q <= item;
    @(negedge clk_i);
    while (!in_ready_o) begin
      @(negedge clk_i);
    end
    unfilter_byte(item, has_res, res);
    if (has_res) recon_q.push_back(res);
    @(posedge clk_i);
  endtask

  task automatic send_row(input logic [7:0] filt, input logic start, input int unsigned n_data);
    int unsigned k;
    logic [7:0] val;
    send_byte(filt, start);
    for (k = 0; k < n_data; k++) begin
      case (k % 4)
        0: val = 8'h00;
        1: val = 8'hFF;
        default: val = 8'($urandom);
      endcase
      send_byte(val, 1'b0);
    end
  endtask

  task automatic settle_pipeline();
    in_valid_q <= 1'b0;
    while (recon_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_q <= 1'b1;
    cfg_idx_q <= idx;
    cfg_data_q <= CfgDataW'(value);
    @(posedge clk_i);
    cfg_we_q <= 1'b0;
    if (idx == RegPixelBytes) pix_cfg = value & 32'hF;
    else len_cfg = value & 32'h3FFF;
    @(posedge clk_i);
  endtask

  task automatic test_reset_config();
    send_row(8'(FiltSub), 1'b0, 10);
    send_row(8'(FiltUp), 1'b1, 8);
    settle_pipeline();
  endtask

  task automatic test_each_filter();
    write_reg(RegPixelBytes, 1);
    write_reg(RegLineBytes, 3);
    send_row(8'(FiltNone), 1'b1, 3);
    send_row(8'(FiltSub), 1'b0, 3);
    send_row(8'(FiltUp), 1'b0, 3);
    send_row(8'(FiltPaeth), 1'b0, 3);
    send_row(AvgCode, 1'b0, 3);
    send_row(8'hFF, 1'b0, 3);
    send_row(8'(FiltBad), 1'b0, 3);
    send_row(8'(FiltPaeth), 1'b0, 3);
    settle_pipeline();
  endtask

  task automatic test_pixel_extremes();
    int unsigned pick;
    int unsigned sizes [3];
    sizes = '{0, 8, 15};
    write_reg(RegLineBytes, 12);
    for (pick = 0; pick < 3; pick++) begin
      write_reg(RegPixelBytes, sizes[pick]);
      send_row(8'(FiltSub), 1'b1, 12);
      send_row(8'(FiltPaeth), 1'b0, 12);
      send_row(8'(FiltUp), 1'b0, 12);
      settle_pipeline();
    end
  endtask

  task automatic test_line_extremes();
    write_reg(RegPixelBytes, 2);
    write_reg(RegLineBytes, 0);
    send_row(8'(FiltSub), 1'b1, 1);
    send_row(8'(FiltPaeth), 1'b0, 1);
    send_row(8'(FiltUp), 1'b0, 1);
    settle_pipeline();
    write_reg(RegLineBytes, 1);
    send_row(8'(FiltUp), 1'b1, 1);
    send_row(8'(FiltPaeth), 1'b0, 1);
    settle_pipeline();
    write_reg(RegPixelBytes, 3);
    write_reg(RegLineBytes, 16383);
    send_row(8'(FiltNone), 1'b1, 120);
    send_row(8'(FiltPaeth), 1'b0, 40);
    settle_pipeline();
  endtask

  task automatic test_config_mid_line();
    write_reg(RegLineBytes, 10);
    write_reg(RegPixelBytes, 2);
    send_row(8'(FiltSub), 1'b1, 10);
    send_row(8'(FiltUp), 1'b0, 6);
    settle_pipeline();
    // The open line is already past the new length, so its next byte closes it.
    write_reg(RegLineBytes, 4);
    send_byte(8'hA5, 1'b0);
    send_row(8'(FiltPaeth), 1'b0, 4);
    send_row(8'(FiltSub), 1'b0, 2);
    settle_pipeline();
    write_reg(RegPixelBytes, 6);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hC3, 1'b0);
    settle_pipeline();
  endtask

  task automatic test_random_stream();
    int unsigned n, sel;
    logic [7:0] raw;
    logic start;
    for (n = 0; n < RandomItems; n++) begin
      if (n % 120 == 119) begin
        settle_pipeline();
        if ($urandom_range(0, 2) != 0) write_reg(RegPixelBytes, $urandom_range(0, 15));
        sel = $urandom_range(0, 9);
        if (sel == 0) write_reg(RegLineBytes, 0);
        else if (sel == 1) write_reg(RegLineBytes, $urandom_range(100, 300));
        else write_reg(RegLineBytes, $urandom_range(1, 16));
      end
      if (col_pos == 0) begin
        start = ($urandom_range(0, 7) == 0);
        sel = $urandom_range(0, 9);
        if (sel < 8) raw = 8'(usable_filt[sel % 4]);
        else if (sel == 8) raw = AvgCode;
        else raw = 8'($urandom_range(5, 255));
      end else begin
        start = ($urandom_range(0, 49) == 0);
        raw = 8'($urandom);
      end
      send_byte(raw, start);
    end
    settle_pipeline();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_each_filter();
    test_pixel_extremes();
    test_line_extremes();
    test_config_mid_line();
    test_random_stream();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && recon_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pngu_pkg.sv
rtl/pngu_ram.sv
rtl/png_scanline_unfilter.sv
tb/png_scanline_unfilter_tb.sv
